@@ design/rc5etd_pkg.sv @@
// ----------------------------------------------------------------------------
// RC5 edge timing decoder package
// Shared payload types, event modes, status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package rc5etd_pkg;

    localparam int HALF_W = 13;
    localparam int TOL_W  = 12;
    localparam int POS_W  = 5;
    localparam int TIME_W = 16;
    localparam int WORD_W = 16;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 2;

    // Event modes
    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_FALL    = 2'd1;
    localparam logic [1:0] MODE_RISE    = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_BUSY        = 3'd0;
    localparam logic [2:0] ST_FRAME_DONE  = 3'd1;
    localparam logic [2:0] ST_LONG        = 3'd2;
    localparam logic [2:0] ST_SHORT       = 3'd3;
    localparam logic [2:0] ST_WRONG_STATE = 3'd4;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_HALF_BIT = 2'd0;
    localparam logic [IDX_W-1:0] REG_TOL      = 2'd1;
    localparam logic [IDX_W-1:0] REG_LAST_POS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [HALF_W-1:0] HALF_BIT_RST = 13'd889;
    localparam logic [TOL_W-1:0]  TOL_RST      = 12'd200;
    localparam logic [POS_W-1:0]  LAST_POS_RST = 5'd25;

    // Positions that mean idle and synchronized
    localparam logic [POS_W-1:0] POS_IDLE = 5'd1;
    localparam logic [POS_W-1:0] POS_SYNC = 5'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] edge_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] code_word;
    } out_item_t;

endpackage

@@ design/rc5_edge_timing_decoder.sv @@
// ----------------------------------------------------------------------------
// RC5 edge timing decoder
// Decodes a Manchester-coded RC5 frame from timer captures of its edges and
// reports status, half-bit position and code word for every event.
// ----------------------------------------------------------------------------
// Path: an event passes the input register, then the result register.
// Throughput: one event per cycle unless stalled; the decoder state is updated
// as the result register loads, so back-to-back events see each other's state.
// Reset: rst_n clears the pipeline, the decoder state (position idle, empty
// code word, previous edge time zero) and loads the register defaults.
module rc5_edge_timing_decoder
    import rc5etd_pkg::*;
#(
    parameter int FRAME_BITS = 13
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    localparam logic [POS_W:0] POS_LIMIT = (POS_W+1)'(2 * FRAME_BITS);

    logic [HALF_W-1:0] half_bit_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [POS_W-1:0]  last_pos_reg;

    logic              s1_valid_reg;
    in_item_t          s1_data_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [TIME_W-1:0] prev_time_reg;
    logic [TIME_W-1:0] prev_time_next;
    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [2:0]        status_next;

    logic              out_load;
    logic              s1_load;

    // Interval and thresholds; the widened interval and thresholds are signed so negative lower bounds never fire.
    logic [TIME_W-1:0]  delta;
    logic signed [17:0] t_s;
    logic signed [17:0] h_s;
    logic signed [17:0] e_s;
    logic signed [17:0] lo_one;
    logic signed [17:0] lo_two;
    logic signed [17:0] hi_two;
    logic signed [17:0] hi_three;
    logic signed [17:0] hi_four;
    logic signed [17:0] mid_three;
    logic signed [17:0] mid_five;
    logic signed [17:0] mid_seven;

    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load  = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !out_load;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign delta     = s1_data_reg.edge_time - prev_time_reg;
    assign t_s       = signed'({2'b00, delta});
    assign h_s       = signed'({5'b0, half_bit_reg});
    assign e_s       = signed'({6'b0, tol_reg});
    assign lo_one    = h_s - e_s;
    assign lo_two    = (h_s <<< 1) - e_s;
    assign hi_two    = (h_s <<< 1) + e_s;
    assign hi_three  = h_s * 18'sd3 + e_s;
    assign hi_four   = (h_s <<< 2) + e_s;
    assign mid_three = (h_s * 18'sd3) >>> 1;
    assign mid_five  = (h_s * 18'sd5) >>> 1;
    assign mid_seven = (h_s * 18'sd7) >>> 1;

    always_comb
    begin
        logic [POS_W:0] pos_sum;
        pos_sum        = {1'b0, position_reg};
        prev_time_next = prev_time_reg;
        position_next  = position_reg;
        word_next      = word_reg;
        status_next    = ST_BUSY;
        case (s1_data_reg.mode)
            MODE_RESTART:
            begin
                position_next = POS_IDLE;
                word_next     = '0;
            end
            MODE_FALL:
            begin
                prev_time_next = s1_data_reg.edge_time;
                if (position_reg == POS_IDLE)
                begin
                    pos_sum = {1'b0, POS_SYNC};
                end
                else if (position_reg[0])
                begin
                    if (t_s > hi_three)
                    begin
                        status_next = ST_LONG;
                    end
                    else if (t_s < lo_two)
                    begin
                        status_next = ST_SHORT;
                    end
                    else if (t_s > mid_five)
                    begin
                        word_next = {word_reg[WORD_W-2:0], 1'b1};
                        pos_sum   = pos_sum + (POS_W+1)'(3);
                    end
                    else
                    begin
                        word_next = {word_reg[WORD_W-2:0], 1'b0};
                        pos_sum   = pos_sum + (POS_W+1)'(2);
                    end
                end
                else
                begin
                    if (t_s > hi_four)
                    begin
                        status_next = ST_LONG;
                    end
                    else if (t_s < lo_two)
                    begin
                        status_next = ST_SHORT;
                    end
                    else if (t_s > mid_seven)
                    begin
                        word_next = {word_reg[WORD_W-3:0], 2'b01};
                        pos_sum   = pos_sum + (POS_W+1)'(4);
                    end
                    else if (t_s > mid_five)
                    begin
                        word_next = {word_reg[WORD_W-3:0], 2'b00};
                        pos_sum   = pos_sum + (POS_W+1)'(3);
                    end
                    else
                    begin
                        word_next = {word_reg[WORD_W-2:0], 1'b1};
                        pos_sum   = pos_sum + (POS_W+1)'(2);
                    end
                end
                // A timing error resynchronizes on the next half bit.
                if (status_next == ST_LONG || status_next == ST_SHORT)
                begin
                    position_next = POS_SYNC;
                end
                else if (pos_sum > POS_LIMIT)
                begin
                    position_next = POS_IDLE;
                    status_next   = ST_FRAME_DONE;
                end
                else
                begin
                    position_next = pos_sum[POS_W-1:0];
                end
            end
            MODE_RISE:
            begin
                prev_time_next = s1_data_reg.edge_time;
                if (position_reg != last_pos_reg)
                begin
                    status_next = ST_WRONG_STATE;
                end
                else
                begin
                    position_next = POS_IDLE;
                    if (t_s > hi_two)
                    begin
                        status_next = ST_LONG;
                    end
                    else if (t_s < lo_one)
                    begin
                        status_next = ST_SHORT;
                    end
                    else
                    begin
                        status_next = ST_FRAME_DONE;
                        word_next   = {word_reg[WORD_W-2:0], (t_s > mid_three)};
                    end
                end
            end
            default:
            begin
                status_next = ST_WRONG_STATE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg <= HALF_BIT_RST;
            tol_reg      <= TOL_RST;
            last_pos_reg <= LAST_POS_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_HALF_BIT: half_bit_reg <= cfg_data[HALF_W-1:0];
                REG_TOL:      tol_reg      <= cfg_data[TOL_W-1:0];
                REG_LAST_POS: last_pos_reg <= cfg_data[POS_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_time_reg <= '0;
            position_reg  <= POS_IDLE;
            word_reg      <= '0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                prev_time_reg <= prev_time_next;
                position_reg  <= position_next;
                word_reg      <= word_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= in_data;
        end
        if (out_load)
        begin
            out_data_reg.status    <= status_next;
            out_data_reg.position  <= position_next;
            out_data_reg.code_word <= word_next;
        end
    end

endmodule

@@ design/rc5etd_checker.sv @@
// ----------------------------------------------------------------------------
// RC5 edge timing decoder checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rc5etd_checker
    import rc5etd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A finished frame always returns the decoder to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FRAME_DONE |-> out_data.position == POS_IDLE)
        else $error("frame done without idle position");

    // Timing errors leave the decoder idle or resynchronized.
    a_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_LONG || out_data.status == ST_SHORT)
        |-> out_data.position == POS_IDLE || out_data.position == POS_SYNC)
        else $error("timing error with unexpected position");

    // Status codes beyond wrong state are never produced.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_WRONG_STATE)
        else $error("status code out of range");

endmodule

bind rc5_edge_timing_decoder rc5etd_checker u_rc5etd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
